/* rtl/core/csq_pkg.sv */
// csq_pkg: shared types and constants of the commissioning sequencer
// phase, event and action codes, flag and action-pair structs, queue sizing
// no dependencies
package csq_pkg;

	localparam int unsigned GEN_WIDTH_DEF = 32;
	localparam int unsigned ID_WIDTH_DEF  = 32;
	localparam int unsigned OP_WIDTH      = 5;
	localparam int unsigned ACT_WIDTH     = 4;
	localparam int unsigned FIFO_DEPTH    = 4;
	localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_PREP    = 4'd1,
		PH_RADIO   = 4'd2,
		PH_START   = 4'd3,
		PH_ADV     = 4'd4,
		PH_SESSION = 4'd5,
		PH_APPLY   = 4'd6,
		PH_RETURN  = 4'd7,
		PH_RESTORE = 4'd8
	} csq_phase_t;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_OPEN              = 5'd0,
		OP_IDENTITY_READY    = 5'd1,
		OP_RADIO_ACQUIRED    = 5'd2,
		OP_TRANSPORT_READY   = 5'd3,
		OP_AUTHENTICATED     = 5'd4,
		OP_TRUST_STAGED      = 5'd5,
		OP_TRUST_FAILED      = 5'd6,
		OP_CANDIDATE_RX      = 5'd7,
		OP_CANDIDATE_STAGED  = 5'd8,
		OP_WIFI_CONNECTED    = 5'd9,
		OP_ROUTE_VALIDATED   = 5'd10,
		OP_COMMITTED         = 5'd11,
		OP_COMMIT_FAILED     = 5'd12,
		OP_CTRL_TERMINAL     = 5'd13,
		OP_ROUTE_FAILED      = 5'd14,
		OP_ROLLED_BACK       = 5'd15,
		OP_WINDOW_EXPIRED    = 5'd16,
		OP_CANCEL            = 5'd17,
		OP_IDENTITY_FAILED   = 5'd18,
		OP_RADIO_FAILED      = 5'd19,
		OP_START_FAILED      = 5'd20,
		OP_TRANSPORT_LOST    = 5'd21,
		OP_TRANSPORT_STOPPED = 5'd22,
		OP_MODE_RESTORED     = 5'd23,
		OP_STATION_READY     = 5'd24
	} csq_op_t;

	typedef enum logic [ACT_WIDTH-1:0] {
		A_PUBLISH  = 4'd0,
		A_STOP     = 4'd1,
		A_ROLLBACK = 4'd2,
		A_IDENTITY = 4'd3,
		A_RADIO    = 4'd4,
		A_START    = 4'd5,
		A_STAGE    = 4'd6,
		A_VALIDATE = 4'd7,
		A_COMMIT   = 4'd8,
		A_RESTORE  = 4'd9
	} csq_action_t;

	typedef struct packed {
		logic trust;
		logic cand;
		logic route_asked;
		logic route_ok;
		logic commit_asked;
		logic committed;
		logic rollback_asked;
		logic stop_asked;
		logic restore_asked;
	} csq_flags_t;

	typedef struct packed {
		logic [1:0]  count;
		csq_action_t a0;
		csq_action_t a1;
	} csq_acts_t;

endpackage

/* rtl/core/commissioning_sequencer_fsm.sv */
// commissioning_sequencer_fsm: top level of the commissioning sequencer
// event input register, session state, csq_decode and csq_result_fifo
// depends on csq_pkg, csq_decode, csq_result_fifo
//
//   channel | handshake             | payload
//   event   | evt_valid / evt_stall | operation, event_generation, event_candidate, ...
//   action  | act_valid / act_stall | action, out_generation, out_candidate, ..., last
//
// an event is registered at its transfer and decoded from that register; its actions
// are written into the result queue and show on the action channel one action per
// cycle while act_stall is low; the single action port sets the sustained rate
// a four-entry result queue holds actions; events stall while it has under two free
// reset clears phase, generation, candidate, flags and the queue at once
module commissioning_sequencer_fsm #(
	parameter int unsigned GEN_WIDTH = csq_pkg::GEN_WIDTH_DEF,
	parameter int unsigned ID_WIDTH  = csq_pkg::ID_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          evt_valid,
	output logic                          evt_stall,
	input  logic [csq_pkg::OP_WIDTH-1:0]  operation,
	input  logic [GEN_WIDTH-1:0]          event_generation,
	input  logic [ID_WIDTH-1:0]           event_candidate,
	input  logic                          event_candidate_present,
	input  logic                          advert_present,
	input  logic                          endpoints_ok,
	input  logic                          security_ok,
	output logic                          act_valid,
	input  logic                          act_stall,
	output logic [csq_pkg::ACT_WIDTH-1:0] action,
	output logic [GEN_WIDTH-1:0]          out_generation,
	output logic [ID_WIDTH-1:0]           out_candidate,
	output logic                          out_candidate_present,
	output logic                          last
);

	logic                         valid_s1;
	logic [csq_pkg::OP_WIDTH-1:0] op_s1;
	logic [GEN_WIDTH-1:0]         egen_s1;
	logic [ID_WIDTH-1:0]          ecand_s1;
	logic                         epres_s1;
	logic                         adv_s1;
	logic                         endp_s1;
	logic                         sec_s1;

	csq_pkg::csq_phase_t  phase_q;
	logic [GEN_WIDTH-1:0] gen_q;
	logic [ID_WIDTH-1:0]  cand_q;
	logic                 pres_q;
	csq_pkg::csq_flags_t  flags_q;

	csq_pkg::csq_phase_t  phase_nxt;
	logic [GEN_WIDTH-1:0] gen_nxt;
	logic [ID_WIDTH-1:0]  cand_nxt;
	logic                 pres_nxt;
	csq_pkg::csq_flags_t  flags_nxt;
	csq_pkg::csq_acts_t   acts;

	logic room2;
	logic proc;

	assign proc      = valid_s1 && room2;
	assign evt_stall = valid_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			op_s1    <= operation;
			egen_s1  <= event_generation;
			ecand_s1 <= event_candidate;
			epres_s1 <= event_candidate_present;
			adv_s1   <= advert_present;
			endp_s1  <= endpoints_ok;
			sec_s1   <= security_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= csq_pkg::PH_IDLE;
			gen_q   <= '0;
			cand_q  <= '0;
			pres_q  <= 1'b0;
			flags_q <= '0;
		end else if (proc) begin
			phase_q <= phase_nxt;
			gen_q   <= gen_nxt;
			cand_q  <= cand_nxt;
			pres_q  <= pres_nxt;
			flags_q <= flags_nxt;
		end
	end

	csq_decode #(
		.GEN_WIDTH (GEN_WIDTH),
		.ID_WIDTH  (ID_WIDTH)
	) u_decode (
		.op        (op_s1),
		.egen      (egen_s1),
		.ecand     (ecand_s1),
		.epres     (epres_s1),
		.adv       (adv_s1),
		.endp      (endp_s1),
		.sec       (sec_s1),
		.phase     (phase_q),
		.gen       (gen_q),
		.cand      (cand_q),
		.pres      (pres_q),
		.flags     (flags_q),
		.phase_nxt (phase_nxt),
		.gen_nxt   (gen_nxt),
		.cand_nxt  (cand_nxt),
		.pres_nxt  (pres_nxt),
		.flags_nxt (flags_nxt),
		.acts      (acts)
	);

	// actions carry the post-event generation and candidate
	csq_result_fifo #(
		.GEN_WIDTH (GEN_WIDTH),
		.ID_WIDTH  (ID_WIDTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (proc),
		.acts       (acts),
		.gen        (gen_nxt),
		.cand       (cand_nxt),
		.pres       (pres_nxt),
		.room2      (room2),
		.out_valid  (act_valid),
		.out_stall  (act_stall),
		.out_action (action),
		.out_gen    (out_generation),
		.out_cand   (out_candidate),
		.out_pres   (out_candidate_present),
		.out_last   (last)
	);

endmodule

/* rtl/core/csq_decode.sv */
// csq_decode: next-state and action logic for one registered event
// depends on csq_pkg
module csq_decode #(
	parameter int unsigned GEN_WIDTH = csq_pkg::GEN_WIDTH_DEF,
	parameter int unsigned ID_WIDTH  = csq_pkg::ID_WIDTH_DEF
) (
	input  logic [csq_pkg::OP_WIDTH-1:0] op,
	input  logic [GEN_WIDTH-1:0]         egen,
	input  logic [ID_WIDTH-1:0]          ecand,
	input  logic                         epres,
	input  logic                         adv,
	input  logic                         endp,
	input  logic                         sec,
	input  csq_pkg::csq_phase_t          phase,
	input  logic [GEN_WIDTH-1:0]         gen,
	input  logic [ID_WIDTH-1:0]          cand,
	input  logic                         pres,
	input  csq_pkg::csq_flags_t          flags,
	output csq_pkg::csq_phase_t          phase_nxt,
	output logic [GEN_WIDTH-1:0]         gen_nxt,
	output logic [ID_WIDTH-1:0]          cand_nxt,
	output logic                         pres_nxt,
	output csq_pkg::csq_flags_t          flags_nxt,
	output csq_pkg::csq_acts_t           acts
);

	logic [GEN_WIDTH-1:0] gen_inc;
	logic                 tear;
	logic                 match;
	logic                 do_return;
	logic                 do_restore;
	logic                 do_idle;

	always_comb begin
		gen_inc = gen + GEN_WIDTH'(1);
		if (gen_inc == '0) begin
			gen_inc = GEN_WIDTH'(1);
		end
	end

	assign tear  = (phase == csq_pkg::PH_RETURN) || (phase == csq_pkg::PH_RESTORE);
	assign match = (epres == pres) && (!epres || (ecand == cand));

	always_comb begin
		phase_nxt  = phase;
		gen_nxt    = gen;
		cand_nxt   = cand;
		pres_nxt   = pres;
		flags_nxt  = flags;
		acts.count = 2'd0;
		acts.a0    = csq_pkg::A_PUBLISH;
		acts.a1    = csq_pkg::A_PUBLISH;
		do_return  = 1'b0;
		do_restore = 1'b0;
		do_idle    = 1'b0;

		if (csq_pkg::csq_op_t'(op) == csq_pkg::OP_OPEN) begin
			if (phase == csq_pkg::PH_IDLE) begin
				gen_nxt    = gen_inc;
				phase_nxt  = csq_pkg::PH_PREP;
				acts.a1    = csq_pkg::A_IDENTITY;
				acts.count = 2'd2;
			end
		end else if (egen == gen && phase != csq_pkg::PH_IDLE) begin
			unique case (csq_pkg::csq_op_t'(op)) inside
				csq_pkg::OP_IDENTITY_READY: begin
					if (phase == csq_pkg::PH_PREP) begin
						phase_nxt  = csq_pkg::PH_RADIO;
						acts.a1    = csq_pkg::A_RADIO;
						acts.count = 2'd2;
					end
				end
				csq_pkg::OP_RADIO_ACQUIRED: begin
					if (phase == csq_pkg::PH_RADIO) begin
						phase_nxt  = csq_pkg::PH_START;
						acts.a1    = csq_pkg::A_START;
						acts.count = 2'd2;
					end
				end
				csq_pkg::OP_TRANSPORT_READY: begin
					if (phase == csq_pkg::PH_START && adv && endp && sec) begin
						phase_nxt  = csq_pkg::PH_ADV;
						acts.count = 2'd1;
					end
				end
				csq_pkg::OP_AUTHENTICATED: begin
					if (phase == csq_pkg::PH_ADV) begin
						phase_nxt  = csq_pkg::PH_SESSION;
						acts.count = 2'd1;
					end
				end
				csq_pkg::OP_TRUST_STAGED: begin
					if (phase == csq_pkg::PH_SESSION) begin
						flags_nxt.trust = 1'b1;
						acts.count      = 2'd1;
					end
				end
				csq_pkg::OP_TRUST_FAILED: begin
					do_restore = (phase == csq_pkg::PH_SESSION);
				end
				csq_pkg::OP_CANDIDATE_RX: begin
					if (phase == csq_pkg::PH_SESSION && flags.trust && epres) begin
						cand_nxt   = ecand;
						pres_nxt   = 1'b1;
						phase_nxt  = csq_pkg::PH_APPLY;
						acts.a1    = csq_pkg::A_STAGE;
						acts.count = 2'd2;
					end
				end
				csq_pkg::OP_CANDIDATE_STAGED: begin
					if (phase == csq_pkg::PH_APPLY && match) begin
						flags_nxt.cand = 1'b1;
					end
				end
				csq_pkg::OP_WIFI_CONNECTED: begin
					if (phase == csq_pkg::PH_APPLY && flags.cand && !flags.route_asked
					    && match) begin
						flags_nxt.route_asked = 1'b1;
						acts.a0               = csq_pkg::A_VALIDATE;
						acts.count            = 2'd1;
					end
				end
				csq_pkg::OP_ROUTE_VALIDATED: begin
					if (phase == csq_pkg::PH_APPLY && flags.cand && !flags.commit_asked
					    && match) begin
						flags_nxt.route_ok     = 1'b1;
						flags_nxt.commit_asked = 1'b1;
						acts.a0                = csq_pkg::A_COMMIT;
						acts.count             = 2'd1;
					end
				end
				csq_pkg::OP_COMMITTED: begin
					if (phase == csq_pkg::PH_APPLY && flags.trust && flags.route_ok
					    && !flags.committed && match) begin
						flags_nxt.committed = 1'b1;
						acts.count          = 2'd1;
					end
				end
				csq_pkg::OP_COMMIT_FAILED, csq_pkg::OP_ROUTE_FAILED: begin
					do_restore = (phase == csq_pkg::PH_APPLY) && match;
				end
				csq_pkg::OP_CTRL_TERMINAL: begin
					do_return = (phase == csq_pkg::PH_APPLY) && flags.committed;
				end
				csq_pkg::OP_ROLLED_BACK: begin
					if (phase == csq_pkg::PH_RESTORE && match) begin
						flags_nxt.trust = 1'b0;
						flags_nxt.cand  = 1'b0;
						if (!flags.stop_asked) begin
							flags_nxt.stop_asked = 1'b1;
							acts.a0              = csq_pkg::A_STOP;
							acts.count           = 2'd1;
						end
					end
				end
				csq_pkg::OP_WINDOW_EXPIRED, csq_pkg::OP_CANCEL,
				csq_pkg::OP_TRANSPORT_LOST: begin
					do_return  = flags.committed;
					do_restore = !flags.committed;
				end
				csq_pkg::OP_IDENTITY_FAILED, csq_pkg::OP_RADIO_FAILED: begin
					do_idle = 1'b1;
				end
				csq_pkg::OP_START_FAILED: begin
					do_restore = 1'b1;
				end
				csq_pkg::OP_TRANSPORT_STOPPED: begin
					if (tear && !flags.restore_asked) begin
						flags_nxt.restore_asked = 1'b1;
						acts.a0                 = csq_pkg::A_RESTORE;
						acts.count              = 2'd1;
					end
				end
				csq_pkg::OP_MODE_RESTORED: begin
					do_idle = tear && !flags.committed;
				end
				csq_pkg::OP_STATION_READY: begin
					do_idle = tear && flags.committed;
				end
				default: begin
				end
			endcase
		end

		// teardown entry points and the return to idle
		if (do_return && !tear) begin
			phase_nxt  = csq_pkg::PH_RETURN;
			acts.count = 2'd1;
			if (!flags.stop_asked) begin
				flags_nxt.stop_asked = 1'b1;
				acts.a1              = csq_pkg::A_STOP;
				acts.count           = 2'd2;
			end
		end
		if (do_restore && !tear) begin
			phase_nxt  = csq_pkg::PH_RESTORE;
			acts.count = 2'd1;
			if ((flags.trust || flags.cand) && !flags.committed) begin
				if (!flags.rollback_asked) begin
					flags_nxt.rollback_asked = 1'b1;
					acts.a1                  = csq_pkg::A_ROLLBACK;
					acts.count               = 2'd2;
				end
			end else if (!flags.stop_asked) begin
				flags_nxt.stop_asked = 1'b1;
				acts.a1              = csq_pkg::A_STOP;
				acts.count           = 2'd2;
			end
		end
		if (do_idle) begin
			cand_nxt   = '0;
			pres_nxt   = 1'b0;
			flags_nxt  = '0;
			phase_nxt  = csq_pkg::PH_IDLE;
			acts.count = 2'd1;
		end
	end

endmodule

/* rtl/core/csq_result_fifo.sv */
// csq_result_fifo: small result queue, takes up to two actions per cycle
// and presents one per cycle on the action channel while out_stall is low; depends on csq_pkg
module csq_result_fifo #(
	parameter int unsigned GEN_WIDTH = csq_pkg::GEN_WIDTH_DEF,
	parameter int unsigned ID_WIDTH  = csq_pkg::ID_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  csq_pkg::csq_acts_t            acts,
	input  logic [GEN_WIDTH-1:0]          gen,
	input  logic [ID_WIDTH-1:0]           cand,
	input  logic                          pres,
	output logic                          room2,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [csq_pkg::ACT_WIDTH-1:0] out_action,
	output logic [GEN_WIDTH-1:0]          out_gen,
	output logic [ID_WIDTH-1:0]           out_cand,
	output logic                          out_pres,
	output logic                          out_last
);

	localparam int unsigned DEPTH = csq_pkg::FIFO_DEPTH;
	localparam int unsigned PW    = csq_pkg::FIFO_PTR_W;
	localparam int unsigned CW    = csq_pkg::FIFO_CNT_W;

	csq_pkg::csq_action_t act_mem  [DEPTH];
	logic                 last_mem [DEPTH];
	logic [GEN_WIDTH-1:0] gen_mem  [DEPTH];
	logic [ID_WIDTH-1:0]  cand_mem [DEPTH];
	logic                 pres_mem [DEPTH];

	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [1:0]    n_push;
	logic          pop;
	logic [PW-1:0] wr_ptr1;

	assign n_push    = push ? acts.count : 2'd0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room2     = (count_q <= CW'(DEPTH - 2));
	assign wr_ptr1   = wr_ptr_q + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(n_push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			act_mem[wr_ptr_q]  <= acts.a0;
			last_mem[wr_ptr_q] <= (n_push == 2'd1);
			gen_mem[wr_ptr_q]  <= gen;
			cand_mem[wr_ptr_q] <= cand;
			pres_mem[wr_ptr_q] <= pres;
		end
		if (n_push == 2'd2) begin
			act_mem[wr_ptr1]  <= acts.a1;
			last_mem[wr_ptr1] <= 1'b1;
			gen_mem[wr_ptr1]  <= gen;
			cand_mem[wr_ptr1] <= cand;
			pres_mem[wr_ptr1] <= pres;
		end
	end

	assign out_action = act_mem[rd_ptr_q];
	assign out_gen    = gen_mem[rd_ptr_q];
	assign out_cand   = cand_mem[rd_ptr_q];
	assign out_pres   = pres_mem[rd_ptr_q];
	assign out_last   = last_mem[rd_ptr_q];

endmodule

/* rtl/core/csq_checker.sv */
// csq_checker: port-level checks of the commissioning sequencer
// bound to commissioning_sequencer_fsm; depends on csq_pkg
module csq_checker #(
	parameter int unsigned GEN_WIDTH = csq_pkg::GEN_WIDTH_DEF,
	parameter int unsigned ID_WIDTH  = csq_pkg::ID_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          act_valid,
	input logic                          act_stall,
	input logic [csq_pkg::ACT_WIDTH-1:0] action,
	input logic [GEN_WIDTH-1:0]          out_generation,
	input logic [ID_WIDTH-1:0]           out_candidate,
	input logic                          out_candidate_present,
	input logic                          last
);

	// stalled action holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && act_stall |=> act_valid && $stable(action) && $stable(last)
		&& $stable(out_generation) && $stable(out_candidate))
		else $error("stalled action changed");

	// generation skips zero, so every action has one
	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid |-> out_generation != '0)
		else $error("action with zero generation");

	a_cand_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && !out_candidate_present |-> out_candidate == '0)
		else $error("absent candidate not zero");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid |-> action <= csq_pkg::A_RESTORE)
		else $error("action code out of range");

endmodule

bind commissioning_sequencer_fsm csq_checker #(
	.GEN_WIDTH (GEN_WIDTH),
	.ID_WIDTH  (ID_WIDTH)
) u_csq_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.act_valid             (act_valid),
	.act_stall             (act_stall),
	.action                (action),
	.out_generation        (out_generation),
	.out_candidate         (out_candidate),
	.out_candidate_present (out_candidate_present),
	.last                  (last)
);
